/* rtl/ray_voxel_face_crossings_core_macros.svh */
// Assertion macros shared by the ray/voxel crossing RTL.
// Expects i_clk and i_rst_n in the scope of use; no other dependencies.
`ifndef RAY_VOXEL_FACE_CROSSINGS_CORE_MACROS_SVH
`define RAY_VOXEL_FACE_CROSSINGS_CORE_MACROS_SVH

// same-cycle implication
`define RVFC_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RVFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rvfc_pkg.sv */
// Shared constants and helpers for the ray/voxel face crossing core.
// No dependencies.
package rvfc_pkg;

    localparam int MAX_DISTANCE = 16;
    localparam int FRAC_W       = 16;
    localparam int DIST_W       = 21;
    localparam logic [DIST_W-1:0] DIST_MAX  = DIST_W'(MAX_DISTANCE << FRAC_W);
    localparam logic [DIST_W-1:0] CFG_RESET = 21'd327680;

    localparam int ST_W    = 32;
    localparam int CUBE_W  = 16;
    localparam int QUOT_W  = 21;   // quotient bits of every division
    localparam int DVD_W   = 53;   // dividend bits
    localparam int DVS_W   = 32;   // divisor bits
    localparam int EMAG_W  = 21;   // |e| and hit numerators
    localparam int PLANE_W = 18;
    localparam int KCNT_W  = 5;
    localparam int PROD_W  = 64;
    localparam int CMP_W   = 2 * EMAG_W;

    // trunc((v + 1) / 65536) toward zero, saturated to 16 bits
    function automatic logic signed [CUBE_W-1:0] cube_of(input logic signed [34:0] v);
        logic signed [34:0] x;
        logic signed [34:0] r;
        x = v + 35'sd1;
        if (x < 0)
            r = (x + 35'sd65535) >>> FRAC_W;
        else
            r = x >>> FRAC_W;
        if (r > 35'sd32767)
            return 16'sh7fff;
        else if (r < -35'sd32768)
            return 16'sh8000;
        else
            return r[CUBE_W-1:0];
    endfunction

endpackage

/* rtl/rvfc_mul.sv */
// Shared 32x32 unsigned multiplier with registered product.
// Depends on rvfc_pkg.
module rvfc_mul import rvfc_pkg::*; (
    input  logic              i_clk,
    input  logic [31:0]       i_a,
    input  logic [31:0]       i_b,
    output logic [PROD_W-1:0] o_p
);

    logic [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

/* rtl/rvfc_sqrt.sv */
// Bit-serial integer square root of a 64-bit value, two radicand bits per cycle.
// Depends on rvfc_pkg.
module rvfc_sqrt import rvfc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_rad,
    output logic              o_done,
    output logic [31:0]       o_root
);

    logic [PROD_W-1:0] r_x;
    logic [PROD_W-1:0] r_res;
    logic [PROD_W-1:0] r_bit;
    logic              r_done;
    logic [PROD_W-1:0] trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x   <= i_rad;
                r_res <= '0;
                r_bit <= PROD_W'(1) << (PROD_W - 2);
            end else if (r_bit != '0) begin
                if (r_x >= trial) begin
                    r_x   <= r_x - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit == PROD_W'(1))
                    r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[31:0];

endmodule

/* rtl/rvfc_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle, QUOT_W bits.
// Caller guarantees dividend < divisor << QUOT_W. Depends on rvfc_pkg.
module rvfc_div import rvfc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DVD_W-1:0]  i_dividend,
    input  logic [DVS_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [QUOT_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [QUOT_W-1:0] r_low;
    logic [QUOT_W-1:0] r_quot;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;
    logic [DVS_W:0]    shifted;
    logic              qbit;

    assign shifted = {r_rem, r_low[QUOT_W-1]};
    assign qbit    = shifted >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem <= i_dividend[DVD_W-1:QUOT_W];
                r_low <= i_dividend[QUOT_W-1:0];
                r_dvs <= i_divisor;
                r_cnt <= CNT_W'(QUOT_W);
            end else if (r_cnt != '0) begin
                r_rem  <= qbit ? DVS_W'(shifted - {1'b0, r_dvs}) : shifted[DVS_W-1:0];
                r_low  <= r_low << 1;
                r_quot <= {r_quot[QUOT_W-2:0], qbit};
                r_cnt  <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1))
                    r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* rtl/ray_voxel_face_crossings_core.sv */
// Ray to voxel-grid face crossings: sequencer, per-axis plane walkers and result register.
// Depends on rvfc_pkg, rvfc_mul, rvfc_sqrt, rvfc_div and the assertion macro header.
//
// One ray at a time: the core takes a ray beat, then stays busy until the last result
// beat for that ray has been taken. Setup runs three squares, a 32-step root and three
// 21-step divisions; each crossing then runs three 21-step divisions on the shared
// divider plus the t compares on the shared multiplier. Crossings are produced by
// walking each axis's planes in order and merging the three streams by t, so no sort
// buffer exists. A ray with no crossing yields one beat with hit_valid low and last
// high. The cast distance register may be written at any time the core is idle;
// values above 16.0 saturate.
`include "ray_voxel_face_crossings_core_macros.svh"

module ray_voxel_face_crossings_core import rvfc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [DIST_W-1:0]        i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [ST_W-1:0]   i_start_x,
    input  logic signed [ST_W-1:0]   i_start_y,
    input  logic signed [ST_W-1:0]   i_start_z,
    input  logic signed [ST_W-1:0]   i_dir_x,
    input  logic signed [ST_W-1:0]   i_dir_y,
    input  logic signed [ST_W-1:0]   i_dir_z,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [CUBE_W-1:0] o_cube_x,
    output logic signed [CUBE_W-1:0] o_cube_y,
    output logic signed [CUBE_W-1:0] o_cube_z,
    output logic [2:0]               o_face,
    output logic [16:0]              o_hit_t,
    output logic                     o_hit_valid,
    output logic                     o_last
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_SQ_MUL   = 5'd1;
    localparam logic [4:0] S_SQ_ACC   = 5'd2;
    localparam logic [4:0] S_SQRT_GO  = 5'd3;
    localparam logic [4:0] S_SQRT_W   = 5'd4;
    localparam logic [4:0] S_E_MUL    = 5'd5;
    localparam logic [4:0] S_E_DIV    = 5'd6;
    localparam logic [4:0] S_E_W      = 5'd7;
    localparam logic [4:0] S_SEEK     = 5'd8;
    localparam logic [4:0] S_SEL      = 5'd9;
    localparam logic [4:0] S_LOADB    = 5'd10;
    localparam logic [4:0] S_CMP1     = 5'd11;
    localparam logic [4:0] S_CMP2     = 5'd12;
    localparam logic [4:0] S_CMP3     = 5'd13;
    localparam logic [4:0] S_TAKE     = 5'd14;
    localparam logic [4:0] S_OUT_INIT = 5'd15;
    localparam logic [4:0] S_O_MUL    = 5'd16;
    localparam logic [4:0] S_O_DIV    = 5'd17;
    localparam logic [4:0] S_O_W      = 5'd18;
    localparam logic [4:0] S_T_DIV    = 5'd19;
    localparam logic [4:0] S_T_W      = 5'd20;
    localparam logic [4:0] S_NOHIT    = 5'd21;
    localparam logic [4:0] S_EMIT     = 5'd22;

    logic [4:0]                r_state;
    logic [DIST_W-1:0]         r_cfg;
    logic [DIST_W-1:0]         r_dist;
    logic signed [ST_W-1:0]    r_st   [3];
    logic [ST_W-1:0]           r_dmag [3];
    logic [2:0]                r_dneg;
    logic [PROD_W-1:0]         r_sum;
    logic [DVS_W-1:0]          r_len;
    logic [1:0]                r_ax;
    logic                      r_seek_all;
    logic [EMAG_W-1:0]         r_emag [3];
    logic [2:0]                r_eneg;
    logic [KCNT_W-1:0]         r_n    [3];
    logic [KCNT_W-1:0]         r_k    [3];
    logic [2:0]                r_hv;
    logic [EMAG_W-1:0]         r_hnum [3];
    logic signed [PLANE_W-1:0] r_hp   [3];
    logic [1:0]                r_best;
    logic [1:0]                r_cand;
    logic                      r_cand_v;
    logic [EMAG_W-1:0]         r_bnum;
    logic [EMAG_W-1:0]         r_bden;
    logic signed [PLANE_W-1:0] r_bp;
    logic                      r_bneg;
    logic [CMP_W-1:0]          r_p1;
    logic signed [CUBE_W-1:0]  r_cube [3];
    logic [2:0]                r_face;
    logic [16:0]               r_hit_t;
    logic                      r_hit_valid;
    logic                      r_last;
    logic                      r_out_valid;

    logic [1:0]                rd_ax;
    logic [31:0]               mul_a;
    logic [31:0]               mul_b;
    logic [PROD_W-1:0]         prod;
    logic                      sqrt_start;
    logic                      sqrt_done;
    logic [31:0]               sqrt_root;
    logic                      div_start;
    logic [DVD_W-1:0]          div_dvd;
    logic [DVS_W-1:0]          div_dvs;
    logic                      div_done;
    logic [QUOT_W-1:0]         div_q;

    logic signed [34:0]        sk_koff;
    logic signed [34:0]        sk_x;
    logic signed [34:0]        sk_pt;
    logic signed [PLANE_W-1:0] sk_p;
    logic signed [34:0]        sk_num;
    logic signed [34:0]        sk_snum;
    logic                      sk_hit;
    logic                      sk_more;

    logic [21:0]               e_round;
    logic signed [21:0]        ov_sq;
    logic signed [34:0]        ov_v;
    logic [1:0]                sel_best;
    logic [1:0]                sel_cand;
    logic                      sel_cand_v;
    logic [2:0]                nx_ax;
    logic                      nx_v;
    logic [ST_W-1:0]           in_dmag [3];
    logic signed [ST_W-1:0]    in_dir  [3];

    rvfc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    rvfc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_rad   (r_sum),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    rvfc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    assign in_dir[0] = i_dir_x;
    assign in_dir[1] = i_dir_y;
    assign in_dir[2] = i_dir_z;
    for (genvar g = 0; g < 3; g++) begin : g_mag
        assign in_dmag[g] = in_dir[g][ST_W-1] ? ST_W'(-in_dir[g]) : ST_W'(in_dir[g]);
    end

    // single read index into the per-axis registers
    always_comb begin
        case (r_state)
            S_LOADB:                rd_ax = r_best;
            S_CMP1, S_CMP2, S_CMP3: rd_ax = r_cand;
            default:                rd_ax = r_ax;
        endcase
    end

    always_comb begin
        case (r_state)
            S_SQ_MUL: begin
                mul_a = r_dmag[rd_ax];
                mul_b = r_dmag[rd_ax];
            end
            S_E_MUL: begin
                mul_a = r_dmag[rd_ax];
                mul_b = 32'(r_dist);
            end
            S_CMP1: begin
                mul_a = 32'(r_hnum[rd_ax]);
                mul_b = 32'(r_bden);
            end
            S_CMP2: begin
                mul_a = 32'(r_bnum);
                mul_b = 32'(r_emag[rd_ax]);
            end
            S_O_MUL: begin
                mul_a = 32'(r_emag[rd_ax]);
                mul_b = 32'(r_bnum);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign sqrt_start = (r_state == S_SQRT_GO);
    assign div_start  = (r_state == S_E_DIV) || (r_state == S_O_DIV) || (r_state == S_T_DIV);
    assign div_dvd    = (r_state == S_T_DIV) ? DVD_W'({r_bnum, 16'd0}) : prod[DVD_W-1:0];
    assign div_dvs    = (r_state == S_E_DIV) ? r_len : DVS_W'(r_bden);

    // plane walker: candidate plane k of the addressed axis
    always_comb begin
        sk_koff = $signed({14'd0, r_k[rd_ax], 16'd0});
        sk_x    = 35'(r_st[rd_ax]) + (r_eneg[rd_ax] ? -sk_koff : sk_koff);
        sk_pt   = (sk_x < 0) ? ((sk_x + 35'sd65535) >>> FRAC_W) : (sk_x >>> FRAC_W);
        sk_p    = sk_pt[PLANE_W-1:0];
        sk_num  = 35'($signed({sk_p, 16'd0})) - 35'(r_st[rd_ax]);
        sk_snum = r_eneg[rd_ax] ? -sk_num : sk_num;
        sk_hit  = !sk_snum[34] && (sk_snum <= $signed({14'd0, r_emag[rd_ax]}));
        sk_more = r_k[rd_ax] <= r_n[rd_ax];
    end

    assign e_round = 22'(div_q) + 22'd65535;
    assign ov_sq   = r_eneg[rd_ax] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    assign ov_v    = 35'(r_st[rd_ax]) + 35'(ov_sq);

    // lowest live head, then the next live one after it
    always_comb begin
        sel_best   = r_hv[0] ? 2'd0 : (r_hv[1] ? 2'd1 : 2'd2);
        sel_cand   = 2'd2;
        sel_cand_v = 1'b0;
        if (sel_best == 2'd0 && r_hv[1]) begin
            sel_cand   = 2'd1;
            sel_cand_v = 1'b1;
        end else if (sel_best != 2'd2 && r_hv[2]) begin
            sel_cand   = 2'd2;
            sel_cand_v = 1'b1;
        end
    end

    // next axis other than the winner, walking upward
    always_comb begin
        nx_ax = 3'(r_ax) + 3'd1;
        if (nx_ax == 3'(r_best))
            nx_ax = nx_ax + 3'd1;
        nx_v = nx_ax <= 3'd2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= CFG_RESET;
            r_out_valid <= 1'b0;
            r_hv        <= '0;
        end else begin
            if (i_cfg_valid)
                r_cfg <= i_cfg_data;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_st[0]   <= i_start_x;
                        r_st[1]   <= i_start_y;
                        r_st[2]   <= i_start_z;
                        r_dmag[0] <= in_dmag[0];
                        r_dmag[1] <= in_dmag[1];
                        r_dmag[2] <= in_dmag[2];
                        r_dneg    <= {i_dir_z[ST_W-1], i_dir_y[ST_W-1], i_dir_x[ST_W-1]};
                        r_dist    <= (r_cfg > DIST_MAX) ? DIST_MAX : r_cfg;
                        r_sum     <= '0;
                        r_ax      <= 2'd0;
                        r_state   <= S_SQ_MUL;
                    end
                end
                S_SQ_MUL: r_state <= S_SQ_ACC;
                S_SQ_ACC: begin
                    r_sum <= r_sum + prod;
                    if (r_ax == 2'd2) begin
                        r_state <= S_SQRT_GO;
                    end else begin
                        r_ax    <= r_ax + 2'd1;
                        r_state <= S_SQ_MUL;
                    end
                end
                S_SQRT_GO: r_state <= S_SQRT_W;
                S_SQRT_W: begin
                    if (sqrt_done) begin
                        r_len <= sqrt_root;
                        r_ax  <= 2'd0;
                        r_state <= (sqrt_root == '0) ? S_NOHIT : S_E_MUL;
                    end
                end
                S_E_MUL: r_state <= S_E_DIV;
                S_E_DIV: r_state <= S_E_W;
                S_E_W: begin
                    if (div_done) begin
                        r_emag[r_ax] <= div_q;
                        r_eneg[r_ax] <= r_dneg[r_ax] && (div_q != '0);
                        r_n[r_ax]    <= e_round[20:16];
                        r_k[r_ax]    <= KCNT_W'(1);
                        if (r_ax == 2'd2) begin
                            r_ax       <= 2'd0;
                            r_seek_all <= 1'b1;
                            r_state    <= S_SEEK;
                        end else begin
                            r_ax    <= r_ax + 2'd1;
                            r_state <= S_E_MUL;
                        end
                    end
                end
                S_SEEK: begin
                    if (!sk_more || sk_hit) begin
                        r_hv[r_ax] <= sk_more;
                        if (sk_more) begin
                            r_hnum[r_ax] <= sk_snum[EMAG_W-1:0];
                            r_hp[r_ax]   <= sk_p;
                            r_k[r_ax]    <= r_k[r_ax] + KCNT_W'(1);
                        end
                        if (!r_seek_all)
                            r_state <= S_OUT_INIT;
                        else if (r_ax == 2'd2)
                            r_state <= S_SEL;
                        else
                            r_ax <= r_ax + 2'd1;
                    end else begin
                        r_k[r_ax] <= r_k[r_ax] + KCNT_W'(1);
                    end
                end
                S_SEL: begin
                    r_best   <= sel_best;
                    r_cand   <= sel_cand;
                    r_cand_v <= sel_cand_v;
                    r_state  <= (r_hv == '0) ? S_NOHIT : S_LOADB;
                end
                S_LOADB: begin
                    r_bnum  <= r_hnum[rd_ax];
                    r_bden  <= r_emag[rd_ax];
                    r_bp    <= r_hp[rd_ax];
                    r_bneg  <= r_eneg[rd_ax];
                    r_state <= r_cand_v ? S_CMP1 : S_TAKE;
                end
                S_CMP1: r_state <= S_CMP2;
                S_CMP2: begin
                    r_p1    <= prod[CMP_W-1:0];
                    r_state <= S_CMP3;
                end
                S_CMP3: begin
                    // strictly earlier wins; ties keep the lower axis
                    if (r_p1 < prod[CMP_W-1:0]) begin
                        r_best <= r_cand;
                        r_bnum <= r_hnum[rd_ax];
                        r_bden <= r_emag[rd_ax];
                        r_bp   <= r_hp[rd_ax];
                        r_bneg <= r_eneg[rd_ax];
                    end
                    if (r_cand == 2'd1 && r_hv[2]) begin
                        r_cand  <= 2'd2;
                        r_state <= S_CMP1;
                    end else begin
                        r_state <= S_TAKE;
                    end
                end
                S_TAKE: begin
                    r_ax       <= r_best;
                    r_seek_all <= 1'b0;
                    r_state    <= S_SEEK;
                end
                S_OUT_INIT: begin
                    r_cube[r_best] <= cube_of(35'($signed({r_bp, 16'd0})));
                    r_ax           <= (r_best == 2'd0) ? 2'd1 : 2'd0;
                    r_state        <= S_O_MUL;
                end
                S_O_MUL: r_state <= S_O_DIV;
                S_O_DIV: r_state <= S_O_W;
                S_O_W: begin
                    if (div_done) begin
                        r_cube[r_ax] <= cube_of(ov_v);
                        if (nx_v) begin
                            r_ax    <= nx_ax[1:0];
                            r_state <= S_O_MUL;
                        end else begin
                            r_state <= S_T_DIV;
                        end
                    end
                end
                S_T_DIV: r_state <= S_T_W;
                S_T_W: begin
                    if (div_done) begin
                        r_hit_t     <= div_q[16:0];
                        r_face      <= {r_best, r_bneg};
                        r_hit_valid <= 1'b1;
                        r_last      <= (r_hv == '0);
                        r_out_valid <= 1'b1;
                        r_state     <= S_EMIT;
                    end
                end
                S_NOHIT: begin
                    r_cube[0]   <= '0;
                    r_cube[1]   <= '0;
                    r_cube[2]   <= '0;
                    r_face      <= '0;
                    r_hit_t     <= '0;
                    r_hit_valid <= 1'b0;
                    r_last      <= 1'b1;
                    r_out_valid <= 1'b1;
                    r_state     <= S_EMIT;
                end
                S_EMIT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= r_last ? S_IDLE : S_SEL;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cube_x    = r_cube[0];
    assign o_cube_y    = r_cube[1];
    assign o_cube_z    = r_cube[2];
    assign o_face      = r_face;
    assign o_hit_t     = r_hit_t;
    assign o_hit_valid = r_hit_valid;
    assign o_last      = r_last;

    `RVFC_ASSERT(a_one_side_busy, o_out_valid, !o_in_ready, "result beat while taking rays")
    `RVFC_ASSERT(a_nohit_alone, o_out_valid && !o_hit_valid, o_last && o_face == 3'd0 && o_hit_t == 17'd0, "no-hit beat not a clean last")
    `RVFC_ASSERT(a_hit_range, o_out_valid && o_hit_valid, o_hit_t <= 17'd65536 && o_face <= 3'd5, "hit fields out of range")
    `RVFC_ASSERT_NEXT(a_ray_locks, i_in_valid && o_in_ready, !o_in_ready && !o_out_valid, "core free right after a ray")
    `RVFC_ASSERT(a_winner_t_le_one, r_state == S_TAKE, r_bnum <= r_bden, "winning crossing beyond t of one")

endmodule

/* tb/sv/tb.sv */
// Testbench for ray_voxel_face_crossings_core: directed and random rays, scoreboard check.
// Depends on rvfc_pkg and the core RTL; the expected crossings are computed in this file.
module tb;
    import rvfc_pkg::*;

    localparam int  MAX_HITS = 3 * MAX_DISTANCE;
    localparam int  LIMIT    = 3000000;
    localparam longint ONE   = 65536;

    typedef struct {
        logic signed [ST_W-1:0] st[3];
        logic signed [ST_W-1:0] dr[3];
    } ray_t;

    typedef struct packed {
        logic signed [CUBE_W-1:0] cx;
        logic signed [CUBE_W-1:0] cy;
        logic signed [CUBE_W-1:0] cz;
        logic [2:0]               face;
        logic [16:0]              t;
        logic                     hv;
        logic                     last;
    } crossing_t;

    class crossing_scoreboard;
        crossing_t        exp_q[$];
        logic [DIST_W-1:0] dist_reg;

        function new();
            dist_reg = CFG_RESET;
        endfunction

        function longint unsigned root64(longint unsigned x);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= res + b) begin
                    x   = x - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function longint sat16(longint v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return v;
        endfunction

        // expected crossings of one accepted ray beat
        function void note_ray(ray_t r);
            longint st[3], dr[3], e[3];
            int ax[MAX_HITS];
            longint pl[MAX_HITS], nm[MAX_HITS], dn[MAX_HITS];
            int nh, j;
            longint cast_len, n, s, p, num, den, v;
            longint unsigned sum, len;
            crossing_t c;
            nh = 0;
            sum = 0;
            cast_len = longint'(dist_reg);
            if (cast_len > longint'(MAX_DISTANCE) * ONE) cast_len = longint'(MAX_DISTANCE) * ONE;
            for (int a = 0; a < 3; a++) begin
                st[a] = longint'(r.st[a]);
                dr[a] = longint'(r.dr[a]);
                sum += longint'(dr[a] < 0 ? -dr[a] : dr[a]) * longint'(dr[a] < 0 ? -dr[a] : dr[a]);
            end
            len = root64(sum);
            if (len != 0) begin
                for (int a = 0; a < 3; a++) e[a] = (dr[a] * cast_len) / longint'(len);
                for (int a = 0; a < 3; a++) begin
                    n = ((e[a] < 0 ? -e[a] : e[a]) + (ONE - 1)) >>> 16;
                    s = e[a] < 0 ? -1 : 1;
                    for (longint k = 1; k <= n && nh < MAX_HITS; k++) begin
                        p   = (k * s * ONE + st[a]) / ONE;
                        num = p * ONE - st[a];
                        den = e[a];
                        if (den < 0) begin
                            num = -num;
                            den = -den;
                        end
                        if (num >= 0 && num <= den) begin
                            j = nh;
                            // stable insert; equal t keeps axis and plane order
                            while (j > 0 && num * dn[j-1] < nm[j-1] * den) begin
                                ax[j] = ax[j-1]; pl[j] = pl[j-1];
                                nm[j] = nm[j-1]; dn[j] = dn[j-1];
                                j--;
                            end
                            ax[j] = a; pl[j] = p; nm[j] = num; dn[j] = den;
                            nh++;
                        end
                    end
                end
            end
            if (nh == 0) begin
                c = '0;
                c.last = 1'b1;
                exp_q.push_back(c);
                return;
            end
            for (int i = 0; i < nh; i++) begin
                logic signed [CUBE_W-1:0] cb[3];
                for (int b = 0; b < 3; b++) begin
                    if (b == ax[i]) v = pl[i] * ONE;
                    else v = st[b] + (e[b] * nm[i]) / dn[i];
                    cb[b] = CUBE_W'(sat16((v + 1) / ONE));
                end
                c.cx   = cb[0];
                c.cy   = cb[1];
                c.cz   = cb[2];
                c.face = 3'(ax[i] * 2 + (e[ax[i]] < 0 ? 1 : 0));
                c.t    = 17'((nm[i] * ONE) / dn[i]);
                c.hv   = 1'b1;
                c.last = (i == nh - 1);
                exp_q.push_back(c);
            end
        endfunction

        // empty string when the beat matches the oldest expected crossing
        function string check_beat(crossing_t got);
            crossing_t w;
            string m;
            if (exp_q.size() == 0) return "result beat with nothing expected";
            w = exp_q.pop_front();
            m = "";
            if (got.cx !== w.cx) m = {m, $sformatf(" cube_x %0d/%0d", got.cx, w.cx)};
            if (got.cy !== w.cy) m = {m, $sformatf(" cube_y %0d/%0d", got.cy, w.cy)};
            if (got.cz !== w.cz) m = {m, $sformatf(" cube_z %0d/%0d", got.cz, w.cz)};
            if (got.face !== w.face) m = {m, $sformatf(" face %0d/%0d", got.face, w.face)};
            if (got.t !== w.t) m = {m, $sformatf(" hit_t %0d/%0d", got.t, w.t)};
            if (got.hv !== w.hv) m = {m, $sformatf(" hit_valid %0b/%0b", got.hv, w.hv)};
            if (got.last !== w.last) m = {m, $sformatf(" last %0b/%0b", got.last, w.last)};
            if (m != "") m = {"got/exp:", m};
            return m;
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [DIST_W-1:0]        i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic signed [ST_W-1:0]   i_start_x, i_start_y, i_start_z;
    logic signed [ST_W-1:0]   i_dir_x, i_dir_y, i_dir_z;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic signed [CUBE_W-1:0] o_cube_x, o_cube_y, o_cube_z;
    logic [2:0]               o_face;
    logic [16:0]              o_hit_t;
    logic                     o_hit_valid;
    logic                     o_last;

    crossing_scoreboard sb;
    int  errors;
    int  cycles;
    int  idle_in;
    int  idle_out;

    ray_voxel_face_crossings_core u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(string msg);
        $display("mismatch @%0d: %s", cycles, msg);
        errors++;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: random stalls, compare each beat taken
    always @(posedge i_clk) begin
        string m;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                m = sb.check_beat({o_cube_x, o_cube_y, o_cube_z, o_face, o_hit_t,
                                   o_hit_valid, o_last});
                if (m != "") report(m);
            end
            i_out_ready <= ($urandom_range(99) >= idle_out);
        end
    end

    task automatic send_ray(ray_t r);
        if ($urandom_range(99) < idle_in) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_start_x <= r.st[0]; i_start_y <= r.st[1]; i_start_z <= r.st[2];
        i_dir_x <= r.dr[0]; i_dir_y <= r.dr[1]; i_dir_z <= r.dr[2];
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_ray(r);
    endtask

    // hold the ray side until every expected crossing has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.exp_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_dist(logic [DIST_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.dist_reg = d;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic ray_t mk(int sx, int sy, int sz, int dx, int dy, int dz);
        ray_t r;
        r.st[0] = sx; r.st[1] = sy; r.st[2] = sz;
        r.dr[0] = dx; r.dr[1] = dy; r.dr[2] = dz;
        return r;
    endfunction

    function automatic ray_t rand_ray();
        ray_t r;
        int mode;
        mode = $urandom_range(9);
        for (int a = 0; a < 3; a++) begin
            case (mode)
                0: begin
                    r.st[a] = $urandom;
                    r.dr[a] = $urandom;
                end
                9: begin
                    // far out, cube coordinates saturate
                    r.st[a] = $urandom_range(1) ? 32'sh7FF8_0000 + $urandom_range(0, 32'h7_FFFF)
                                                : 32'sh8000_0000 + $urandom_range(0, 32'h7_FFFF);
                    r.dr[a] = int'($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000;
                end
                default: begin
                    r.st[a] = int'($urandom_range(0, 40 << 16)) - (20 << 16);
                    if ($urandom_range(3) == 0) r.st[a] = int'($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
                    r.dr[a] = $urandom_range(1) ? int'($urandom_range(0, 32'h3F_FFFF)) - 32'sh20_0000
                                                : int'($urandom);
                    if (mode == 8 && $urandom_range(1)) r.dr[a] = 0;
                end
            endcase
        end
        return r;
    endfunction

    task automatic random_rays(int cnt);
        for (int i = 0; i < cnt; i++) send_ray(rand_ray());
    endtask

    initial begin
        sb = new();
        errors = 0;
        cycles = 0;
        idle_in = 31;
        idle_out = 66;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_start_x = '0; i_start_y = '0; i_start_z = '0;
        i_dir_x = '0; i_dir_y = '0; i_dir_z = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset distance of 5.0
        send_ray(mk(0, 0, 0, 0, 0, 0));
        send_ray(mk(0, 0, 0, 65536, 0, 0));
        send_ray(mk(32768, 0, 0, -65536, 0, 0));
        send_ray(mk(0, 0, 0, 0, 65536, 0));
        send_ray(mk(0, 32768, 0, 0, -3, 0));
        send_ray(mk(0, 0, 0, 0, 0, 65536));
        send_ray(mk(0, 0, 65536, 0, 0, -65536));
        send_ray(mk(0, 0, 0, 65536, 65536, 65536));     // three-way ties
        send_ray(mk(-98304, 0, 0, 65536, 0, 0));        // two planes truncate to zero
        send_ray(mk(32'sh7FFF_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 65536, 1, -1));
        send_ray(mk(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, -1, -1, -1));
        send_ray(mk(12345, -54321, 999, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000));
        send_ray(mk(-1, -1, -1, 1, 0, 0));
        send_ray(mk(32'sh0000_FFFF, 0, 0, 32'sh8000_0000, 0, 0));
        send_ray(mk(65536 * 3, 65536 * -2, 7, -65536, 65536, 0));
        drain();

        write_dist('0);
        send_ray(mk(0, 0, 0, 65536, 0, 0));
        send_ray(rand_ray());
        send_ray(rand_ray());
        drain();

        write_dist({DIST_W{1'b1}});
        random_rays(40);
        drain();

        idle_in = 66;
        idle_out = 31;
        write_dist(DIST_W'(65536));
        random_rays(30);
        drain();

        write_dist(DIST_W'($urandom_range(1, 32'h1F_FFFF)));
        random_rays(30);
        drain();

        idle_in = 0;
        idle_out = 0;
        write_dist(DIST_MAX);
        random_rays(30);
        drain();

        write_dist(CFG_RESET);
        random_rays(25);
        drain();

        repeat (50) @(posedge i_clk);
        if (sb.exp_q.size() != 0) report($sformatf("%0d crossings never came", sb.exp_q.size()));
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl
rtl/rvfc_pkg.sv
rtl/rvfc_mul.sv
rtl/rvfc_sqrt.sv
rtl/rvfc_div.sv
rtl/ray_voxel_face_crossings_core.sv
tb/sv/tb.sv
